/* rtl/core/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // One input word: a character, or the mark that the source ran out.
    typedef struct packed {
        logic [7:0] char_in;
        logic       stream_end;
    } in_word_t;

    // One result word: a decoded byte and the status of the step.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
    } out_word_t;

    // Result status codes.
    localparam logic [1:0] ST_CONSUMED = 2'd0;
    localparam logic [1:0] ST_BYTE     = 2'd1;
    localparam logic [1:0] ST_OK       = 2'd2;
    localparam logic [1:0] ST_ERR      = 2'd3;

    // Padding mode of the decoder.
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_PAD2   = 3'b010,
        MODE_TAIL   = 3'b100
    } mode_t;

    // Character class of one input character.
    typedef struct packed {
        logic       is_ws;
        logic       is_pad;
        logic       is_sym;
        logic [5:0] sextet;
    } char_class_t;

    localparam logic [7:0] CHAR_PAD        = 8'h3D;
    localparam logic [7:0] DELIM_RESET     = 8'h3C;
    localparam logic [5:0] MASK_HI2        = 6'h30;
    localparam logic [5:0] MASK_MID4       = 6'h3C;
    localparam logic [5:0] MASK_LO4        = 6'h0F;
    localparam logic [5:0] MASK_LO2        = 6'h03;

    // Configuration register map.
    localparam int unsigned PADDR_W        = 3;
    localparam logic        REG_SEL_DELIM  = 1'b0;

endpackage

/* rtl/core/b64d_classify.sv */
// ----------------------------------------------------------------------------
// b64d_classify
// Sorts a character into whitespace, pad, base64 symbol or other, and gives
// the sextet value of a symbol.
// ----------------------------------------------------------------------------
module b64d_classify (
    input  logic [7:0]           char_in,
    output b64d_pkg::char_class_t char_class
);

    logic [7:0] upper_val;
    logic [7:0] lower_val;
    logic [7:0] digit_val;

    // Offsets taken modulo 256; only the low six bits are kept.
    assign upper_val = char_in - 8'h41;
    assign lower_val = char_in - 8'h47;
    assign digit_val = char_in + 8'h04;

    always_comb
    begin
        char_class.is_ws  = (char_in == 8'h20) || ((char_in >= 8'h09) && (char_in <= 8'h0D));
        char_class.is_pad = (char_in == b64d_pkg::CHAR_PAD);
        char_class.is_sym = 1'b1;
        char_class.sextet = 6'd0;
        if ((char_in >= 8'h41) && (char_in <= 8'h5A))
        begin
            char_class.sextet = upper_val[5:0];
        end
        else if ((char_in >= 8'h61) && (char_in <= 8'h7A))
        begin
            char_class.sextet = lower_val[5:0];
        end
        else if ((char_in >= 8'h30) && (char_in <= 8'h39))
        begin
            char_class.sextet = digit_val[5:0];
        end
        else if (char_in == 8'h2B)
        begin
            char_class.sextet = 6'd62;
        end
        else if (char_in == 8'h2F)
        begin
            char_class.sextet = 6'd63;
        end
        else
        begin
            char_class.is_sym = 1'b0;
        end
    end

endmodule

/* rtl/core/b64d_step.sv */
// ----------------------------------------------------------------------------
// b64d_step
// Decoder state (group phase, previous sextet, padding mode) and the
// combinational step that turns one word into one result.
// ----------------------------------------------------------------------------
module b64d_step (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step_en,
    input  b64d_pkg::in_word_t       word,
    input  b64d_pkg::char_class_t    char_class,
    input  logic [7:0]               delimiter,
    output b64d_pkg::out_word_t      result
);

    logic [1:0]      phase_reg;
    logic [1:0]      phase_next;
    logic [5:0]      prev_reg;
    logic [5:0]      prev_next;
    b64d_pkg::mode_t mode_reg;
    b64d_pkg::mode_t mode_next;
    logic            is_delim;
    logic            finish;

    assign is_delim = (word.char_in == delimiter);

    always_comb
    begin
        phase_next      = phase_reg;
        prev_next       = prev_reg;
        mode_next       = mode_reg;
        finish          = 1'b0;
        result.out_byte = 8'd0;
        result.status   = b64d_pkg::ST_CONSUMED;

        if (word.stream_end)
        begin
            finish        = 1'b1;
            result.status = b64d_pkg::ST_ERR;
        end
        else
        begin
            case (mode_reg)
                b64d_pkg::MODE_PAD2:
                begin
                    if (char_class.is_pad)
                    begin
                        mode_next = b64d_pkg::MODE_TAIL;
                    end
                    else
                    begin
                        finish        = 1'b1;
                        result.status = b64d_pkg::ST_ERR;
                    end
                end
                b64d_pkg::MODE_TAIL:
                begin
                    if (is_delim)
                    begin
                        finish        = 1'b1;
                        result.status = b64d_pkg::ST_OK;
                    end
                    else if (!char_class.is_ws)
                    begin
                        finish        = 1'b1;
                        result.status = b64d_pkg::ST_ERR;
                    end
                end
                b64d_pkg::MODE_NORMAL:
                begin
                    if (is_delim)
                    begin
                        finish        = 1'b1;
                        result.status = (phase_reg == 2'd0) ? b64d_pkg::ST_OK
                                                            : b64d_pkg::ST_ERR;
                    end
                    else if (char_class.is_ws)
                    begin
                        if (phase_reg != 2'd0)
                        begin
                            finish        = 1'b1;
                            result.status = b64d_pkg::ST_ERR;
                        end
                    end
                    else if (char_class.is_pad)
                    begin
                        if ((phase_reg == 2'd2) && ((prev_reg & b64d_pkg::MASK_LO4) == 6'd0))
                        begin
                            mode_next = b64d_pkg::MODE_PAD2;
                        end
                        else if ((phase_reg == 2'd3) &&
                                 ((prev_reg & b64d_pkg::MASK_LO2) == 6'd0))
                        begin
                            mode_next = b64d_pkg::MODE_TAIL;
                        end
                        else
                        begin
                            finish        = 1'b1;
                            result.status = b64d_pkg::ST_ERR;
                        end
                    end
                    else if (!char_class.is_sym)
                    begin
                        finish        = 1'b1;
                        result.status = b64d_pkg::ST_ERR;
                    end
                    else
                    begin
                        prev_next  = char_class.sextet;
                        phase_next = phase_reg + 2'd1;
                        if (phase_reg != 2'd0)
                        begin
                            result.status = b64d_pkg::ST_BYTE;
                        end
                        case (phase_reg)
                            2'd1:
                            begin
                                result.out_byte = {prev_reg,
                                    2'((char_class.sextet & b64d_pkg::MASK_HI2) >> 4)};
                            end
                            2'd2:
                            begin
                                result.out_byte = {4'((prev_reg & b64d_pkg::MASK_LO4)),
                                    4'((char_class.sextet & b64d_pkg::MASK_MID4) >> 2)};
                            end
                            2'd3:
                            begin
                                result.out_byte = {2'((prev_reg & b64d_pkg::MASK_LO2)),
                                    char_class.sextet};
                            end
                            default:
                            begin
                                result.out_byte = 8'd0;
                            end
                        endcase
                    end
                end
                default:
                begin
                    finish        = 1'b1;
                    result.status = b64d_pkg::ST_ERR;
                end
            endcase
        end

        // Every end of a field puts the decoder back at its start.
        if (finish)
        begin
            phase_next = 2'd0;
            prev_next  = 6'd0;
            mode_next  = b64d_pkg::MODE_NORMAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            prev_reg  <= 6'd0;
            mode_reg  <= b64d_pkg::MODE_NORMAL;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

/* rtl/core/base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder: one character word in, one result word out.
// ----------------------------------------------------------------------------
// A word accepted into the input register is decoded into the result
// register once that register is free, and leaves from there when dst_stall
// is low.
// Throughput: one word per cycle while the result side keeps up; the decode
// step is combinational logic between the input and result registers.
// Reset: rst_n clears both pipeline stages, the decoder state and sets the
// delimiter to '<'. No clearing pass is needed.
module base64_stream_decoder (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input channel
    input  logic                                 src_valid,
    output logic                                 src_stall,
    input  b64d_pkg::in_word_t                   src_word,
    // Result channel
    output logic                                 dst_valid,
    input  logic                                 dst_stall,
    output b64d_pkg::out_word_t                  dst_word,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [b64d_pkg::PADDR_W-1:0]         paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    // Input register stage. A word sits here while the decode logic works on
    // it; it moves on when the result register is free or being drained.
    logic                s1_valid_reg;
    b64d_pkg::in_word_t  s1_word_reg;

    // Result register stage.
    logic                dst_valid_reg;
    b64d_pkg::out_word_t dst_word_reg;

    logic [7:0]            delim_reg;
    b64d_pkg::char_class_t char_class;
    b64d_pkg::out_word_t   step_result;
    logic                  out_free;
    logic                  s1_adv;
    logic                  src_take;
    logic                  cfg_write;

    // The result register can load when it is empty or its word leaves now.
    assign out_free  = !dst_valid_reg || !dst_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    // The input register takes a new word whenever its current word moves on,
    // so words stream back to back while the result side keeps up.
    assign src_stall = s1_valid_reg && !out_free;
    assign src_take  = src_valid && !src_stall;

    assign dst_valid = dst_valid_reg;
    assign dst_word  = dst_word_reg;

    // Configuration: a single register, the delimiter, at byte address 0.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == b64d_pkg::REG_SEL_DELIM) ? {24'd0, delim_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= b64d_pkg::DELIM_RESET;
        end
        else if (cfg_write && (paddr[2] == b64d_pkg::REG_SEL_DELIM))
        begin
            delim_reg <= pwdata[7:0];
        end
    end

    // Character classification of the word in the input register.
    b64d_classify u_classify (
        .char_in    (s1_word_reg.char_in),
        .char_class (char_class)
    );

    // Decoder state and the combinational decode step. The state advances only
    // when the step's result is written into the result register.
    b64d_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (s1_adv),
        .word       (s1_word_reg),
        .char_class (char_class),
        .delimiter  (delim_reg),
        .result     (step_result)
    );

    // Valid flags of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            if (src_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                dst_valid_reg <= 1'b1;
            end
            else if (!dst_stall)
            begin
                dst_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (src_take)
        begin
            s1_word_reg <= src_word;
        end
        if (s1_adv)
        begin
            dst_word_reg <= step_result;
        end
    end

    // A decoded byte is nonzero only on a byte result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && (dst_word.status != b64d_pkg::ST_BYTE)) |-> (dst_word.out_byte == 8'd0))
        else $error("nonzero byte on a result that carries no byte");

    // The end of the source always closes the field with an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_word_reg.stream_end) |=> (dst_valid && (dst_word.status == b64d_pkg::ST_ERR)))
        else $error("stream end did not give an error result");

    // An accepted word is held in the input register on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        src_take |=> s1_valid_reg)
        else $error("accepted word lost before the decode stage");

    // A result appears only after a word was in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst_valid) |-> $past(s1_valid_reg))
        else $error("result word without a word in the decode stage");

endmodule
